// File: sv/sise_pkg.sv
// shared types, codes and defaults for the sorted id set engine
`default_nettype none

package sise_pkg;

  // default sizing
  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned ID_BITS_DEF  = 32;

  // fixed port widths
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned IDENT_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd2;
  localparam logic [FUNC_W-1:0] FN_COMMON = 3'd3;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] STS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STS_FULL = 2'd2;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic cmp_en;  // capture compare flags against the new key
    logic ins;     // open a slot at the lower bound and write the key
    logic rem;     // close the slot at the lower bound
  } ctl_t;

endpackage

`default_nettype wire

// File: sv/sorted_id_set_engine.sv
// top level: sorted id set built as a shifting row of cells
//
//  channel  | ports                                        | direction
//  ---------+----------------------------------------------+----------
//  command  | start, func_i, ident_i, last_i; busy is out   | in
//  result   | done_o, status_o, found_o, common_count_o,   | out
//           | occupancy_o                                  |
//
// each transaction has an accept cycle and a shift cycle: all cells compare the
// key in the accept cycle, then the hit flag is reduced and the row shifts one place.
// busy is high for the shift cycle, so no command is taken while the row shifts;
// the result strobe follows the shift cycle. reset clears the entry count and
// the running common count; cell contents are not reset. the result strobe lasts
// one cycle and cannot be held off.
`default_nettype none

module sorted_id_set_engine #(
  parameter int unsigned CAPACITY = sise_pkg::CAPACITY_DEF,
  parameter int unsigned ID_BITS  = sise_pkg::ID_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [sise_pkg::FUNC_W-1:0]     func_i,
  input  wire logic [sise_pkg::IDENT_W-1:0]    ident_i,
  input  wire logic                            last_i,
  output logic                                 done_o,
  output logic      [sise_pkg::STATUS_W-1:0]   status_o,
  output logic                                 found_o,
  output logic      [sise_pkg::COUNT_W-1:0]    common_count_o,
  output logic      [sise_pkg::COUNT_W-1:0]    occupancy_o
);
  import sise_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // state codes
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] common_q, common_d;
  logic [CNT_W-1:0] common_shown;

  logic [FUNC_W-1:0]  func_q;
  logic               last_q;
  logic [ID_BITS-1:0] key_q;
  logic [ID_BITS-1:0] new_key;

  logic               accept;
  logic               exec;
  logic               hit;
  logic               full;
  logic               cmp_op;
  ctl_t               ctl;

  logic [ID_BITS-1:0]  cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;

  logic                done_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                found_q;
  logic [COUNT_W-1:0]  common_out_q;
  logic [COUNT_W-1:0]  occ_q;

  assign accept  = start && !busy;
  assign exec    = (state_q == ST_EXEC);
  assign busy    = exec;
  assign new_key = ID_BITS'(ident_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // command capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      last_q <= last_i;
      key_q  <= new_key;
    end
  end

  // membership and row control; compares are enabled in the accept cycle
  assign cmp_op = (func_q == FN_INSERT) || (func_q == FN_REMOVE) ||
                  (func_q == FN_LOOKUP) || (func_q == FN_COMMON);
  assign hit    = cmp_op && (|cell_eq);
  assign full   = (count_q >= CNT_W'(CAPACITY));

  always_comb begin
    ctl.cmp_en = accept;
    ctl.ins    = exec && (func_q == FN_INSERT) && !hit && !full;
    ctl.rem    = exec && (func_q == FN_REMOVE) && hit;
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ID_BITS-1:0] left_data;
    logic               left_lt;
    logic [ID_BITS-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = cell_data[0];
      assign left_lt   = 1'b1;
    end else begin : g_mid
      assign left_data = cell_data[i-1];
      assign left_lt   = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    sise_cell #(
      .ID_BITS(ID_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .valid_i     (CNT_W'(i) < count_q),
      .cmp_key_i   (new_key),
      .ins_key_i   (key_q),
      .left_data_i (left_data),
      .left_lt_i   (left_lt),
      .right_data_i(right_data),
      .data_o      (cell_data[i]),
      .lt_o        (cell_lt[i]),
      .eq_o        (cell_eq[i])
    );
  end

  // counters and status
  always_comb begin
    count_d  = count_q;
    common_d = common_q;
    status_d = STS_DONE;
    unique case (func_q)
      FN_INSERT: begin
        if (hit) begin
          status_d = STS_MISS;
        end else if (full) begin
          status_d = STS_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      FN_REMOVE: begin
        if (hit) begin
          count_d = count_q - CNT_W'(1);
        end else begin
          status_d = STS_MISS;
        end
      end
      FN_LOOKUP: status_d = hit ? STS_DONE : STS_MISS;
      FN_COMMON: begin
        status_d = hit ? STS_DONE : STS_MISS;
        if (hit && (common_q < CNT_W'(CAPACITY))) begin
          common_d = common_q + CNT_W'(1);
        end
      end
      FN_CLEAR: count_d = '0;
      default: ;
    endcase
    common_shown = common_d;
    if ((func_q == FN_COMMON) && last_q) begin
      common_d = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      common_q <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= exec;
      if (exec) begin
        count_q  <= count_d;
        common_q <= common_d;
      end
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q     <= status_d;
      found_q      <= hit;
      common_out_q <= COUNT_W'(common_shown);
      occ_q        <= COUNT_W'(count_d);
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign found_o        = found_q;
  assign common_count_o = common_out_q;
  assign occupancy_o    = occ_q;

endmodule

`default_nettype wire

// File: sv/sise_cell.sv
// one cell of the sorted array: holds one id and shifts with its neighbors
`default_nettype none

module sise_cell #(
  parameter int unsigned ID_BITS = sise_pkg::ID_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire sise_pkg::ctl_t     ctl_i,
  input  wire logic               valid_i,
  input  wire logic [ID_BITS-1:0] cmp_key_i,
  input  wire logic [ID_BITS-1:0] ins_key_i,
  input  wire logic [ID_BITS-1:0] left_data_i,
  input  wire logic               left_lt_i,
  input  wire logic [ID_BITS-1:0] right_data_i,
  output logic      [ID_BITS-1:0] data_o,
  output logic                    lt_o,
  output logic                    eq_o
);
  import sise_pkg::*;

  logic [ID_BITS-1:0] data_q, data_d;
  logic               lt_q, lt_d;
  logic               eq_q, eq_d;

  // compare flags, captured when a transaction is accepted
  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (ctl_i.cmp_en) begin
      lt_d = valid_i && (data_q < cmp_key_i);
      eq_d = valid_i && (data_q == cmp_key_i);
    end
  end

  // cells below the lower bound keep their id, the rest shift on an insert or a remove
  always_comb begin
    data_d = data_q;
    if (ctl_i.ins && !lt_q) begin
      data_d = left_lt_i ? ins_key_i : left_data_i;
    end else if (ctl_i.rem && !lt_q) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    lt_q   <= lt_d;
    eq_q   <= eq_d;
  end

  assign data_o = data_q;
  assign lt_o   = lt_q;
  assign eq_o   = eq_q;

endmodule

`default_nettype wire
